// File: rtl/lock_table_deadlock_detector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lock table deadlock detector
// Shorthand for clocked implications checked under the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef LOCK_TABLE_DEADLOCK_DETECTOR_MACROS_SVH
`define LOCK_TABLE_DEADLOCK_DETECTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTDD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LTDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ltdd_pkg.sv
// ----------------------------------------------------------------------------
// ltdd_pkg
// Shared widths, result codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ltdd_pkg;

	localparam int TID_W = 3;
	localparam int RID_W = 2;
	localparam int ST_W  = 3;

	localparam int DEF_THREADS   = 4;
	localparam int DEF_RESOURCES = 4;

	typedef enum logic [ST_W-1:0] {
		ST_GRANTED  = 3'd0,
		ST_OWNER    = 3'd1,
		ST_WAITING  = 3'd2,
		ST_DEADLOCK = 3'd3,
		ST_IGNORED  = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic decide;
		logic walk;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dec_wait;
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/lock_table_deadlock_detector.sv
// Flow: a request is captured when accepted and decided; only a request that waits is then
// walked through the wait-for graph, and the word is published to the output register once
// that is free. No new request is taken before that publish. The walker follows one
// wait-for edge per cycle through one lock table port.
// Reset: arst_n clears the lock table, wait records and halt flag at once; ready follows.
// ----------------------------------------------------------------------------
// lock_table_deadlock_detector
// Lock table with wait-for graph deadlock detection.
// ----------------------------------------------------------------------------
// Each accepted word is a lock request. A free resource is granted to the
// requesting thread, a repeat request by the owner is reported as such, and a
// request for a busy resource records that the thread now waits on it. After
// recording a wait, the walker visits every waiting thread in ascending order
// and follows its chain of wait and owner edges; the first thread whose chain
// comes back to itself is reported as deadlocked and the block halts, after
// which every request is answered as ignored until reset. Locks are never
// released. The result word sits in an output register, so a new request may
// be taken while the previous result still waits for the consumer.

module lock_table_deadlock_detector #(
	parameter int THREADS   = ltdd_pkg::DEF_THREADS,
	parameter int RESOURCES = ltdd_pkg::DEF_RESOURCES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ltdd_pkg::TID_W-1:0] thread_id,
	input  logic [ltdd_pkg::RID_W-1:0] resource_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ltdd_pkg::ST_W-1:0]  status,
	output logic [ltdd_pkg::TID_W-1:0] holder_thread,
	output logic [ltdd_pkg::TID_W-1:0] deadlock_thread
);

	ltdd_pkg::cmd_t cmd;
	ltdd_pkg::sts_t sts;

	// The controller only sequences; all tables and arithmetic live in the datapath.
	ltdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ltdd_dp #(
		.THREADS   (THREADS),
		.RESOURCES (RESOURCES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.thread_id       (thread_id),
		.resource_id     (resource_id),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.status          (status),
		.holder_thread   (holder_thread),
		.deadlock_thread (deadlock_thread)
	);

endmodule

// File: rtl/ltdd_ctrl.sv
// ----------------------------------------------------------------------------
// ltdd_ctrl
// Sequencer: capture a request, decide it, walk the wait-for graph when it waits, publish.
// ----------------------------------------------------------------------------
`include "lock_table_deadlock_detector_macros.svh"

module ltdd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ltdd_pkg::sts_t sts,
	output ltdd_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECIDE = 4'b0010,
		S_WALK   = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.dec_wait ? S_WALK : S_DONE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`LTDD_ASSERT_IMPL(a_cmd_single, 1'b1, $onehot0(cmd), "more than one datapath command at once")
	`LTDD_ASSERT_NEXT(a_publish_idle, cmd.publish, state_q == S_IDLE, "no return to idle after publish")

endmodule

// File: rtl/ltdd_dp.sv
// ----------------------------------------------------------------------------
// ltdd_dp
// Lock table, wait records, halt flag, graph walker and result register.
// ----------------------------------------------------------------------------
`include "lock_table_deadlock_detector_macros.svh"

module ltdd_dp #(
	parameter int THREADS   = ltdd_pkg::DEF_THREADS,
	parameter int RESOURCES = ltdd_pkg::DEF_RESOURCES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ltdd_pkg::cmd_t             cmd,
	output ltdd_pkg::sts_t             sts,
	input  logic [ltdd_pkg::TID_W-1:0] thread_id,
	input  logic [ltdd_pkg::RID_W-1:0] resource_id,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [ltdd_pkg::ST_W-1:0]  status,
	output logic [ltdd_pkg::TID_W-1:0] holder_thread,
	output logic [ltdd_pkg::TID_W-1:0] deadlock_thread
);

	localparam int TIX_W = $clog2(THREADS);
	localparam int TV_W  = $clog2(THREADS + 1);
	localparam int RIX_W = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

	logic [ltdd_pkg::TID_W-1:0] req_t_q;
	logic [ltdd_pkg::RID_W-1:0] req_r_q;

	logic [ltdd_pkg::TID_W-1:0] owner_q [RESOURCES];
	logic [THREADS-1:0]         wait_valid_q;
	logic [RIX_W-1:0]           wait_res_q [THREADS];
	logic                       halted_q;

	logic [TV_W-1:0] start_q;
	logic [TV_W-1:0] cur_q;
	logic [TV_W-1:0] cnt_q;

	logic [ltdd_pkg::ST_W-1:0]  res_status_q;
	logic [ltdd_pkg::TID_W-1:0] res_holder_q;
	logic [ltdd_pkg::TID_W-1:0] res_dead_q;

	logic                       out_valid_q;
	logic [ltdd_pkg::ST_W-1:0]  out_status_q;
	logic [ltdd_pkg::TID_W-1:0] out_holder_q;
	logic [ltdd_pkg::TID_W-1:0] out_dead_q;

	logic                       r_ok;
	logic                       t_ok;
	logic [RIX_W-1:0]           req_rix;
	logic [TIX_W-1:0]           req_tix;
	logic [TIX_W-1:0]           cur_ix;
	logic                       wv;
	logic [RIX_W-1:0]           wr;
	logic [RIX_W-1:0]           rd_addr;
	logic [ltdd_pkg::TID_W-1:0] owner_rd;
	logic                       ignored;
	logic                       is_free;
	logic                       is_owner;
	logic                       hit;
	logic                       fail;
	logic                       final_start;

	always_comb begin
		r_ok    = (int'(req_r_q) < RESOURCES);
		t_ok    = (req_t_q != '0) && (int'(req_t_q) <= THREADS);
		req_rix = RIX_W'(req_r_q);
		req_tix = TIX_W'(req_t_q - 1'b1);
		cur_ix  = TIX_W'(cur_q - 1'b1);
		wv      = wait_valid_q[cur_ix];
		wr      = wait_res_q[cur_ix];
		// One read port on the lock table: request lookup or walk step.
		rd_addr  = cmd.walk ? wr : req_rix;
		owner_rd = owner_q[rd_addr];

		ignored  = halted_q || !t_ok || !r_ok;
		is_free  = (owner_rd == '0);
		is_owner = (owner_rd == req_t_q);

		hit         = wv && !is_free && (TV_W'(owner_rd) == start_q);
		fail        = !hit && (!wv || is_free || (cnt_q == TV_W'(THREADS - 1)));
		final_start = (start_q == TV_W'(THREADS));

		sts.dec_wait  = !ignored && !is_free && !is_owner;
		sts.walk_done = hit || (fail && final_start);
		sts.out_free  = !out_valid_q || out_ready;
	end

	// State with a defined reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RESOURCES; i++) begin
				owner_q[i] <= '0;
			end
			for (int i = 0; i < THREADS; i++) begin
				wait_res_q[i] <= '0;
			end
			wait_valid_q <= '0;
			halted_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.decide && !ignored) begin
				if (is_free) begin
					owner_q[req_rix] <= req_t_q;
				end else if (!is_owner) begin
					wait_valid_q[req_tix] <= 1'b1;
					wait_res_q[req_tix]   <= req_rix;
				end
			end
			if (cmd.walk && hit) begin
				halted_q <= 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, walker and result payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_t_q <= thread_id;
			req_r_q <= resource_id;
		end
		if (cmd.decide) begin
			res_dead_q   <= '0;
			res_holder_q <= r_ok ? owner_rd : '0;
			start_q      <= TV_W'(1);
			cur_q        <= TV_W'(1);
			cnt_q        <= '0;
			if (ignored) begin
				res_status_q <= ltdd_pkg::ST_IGNORED;
			end else if (is_free) begin
				res_status_q <= ltdd_pkg::ST_GRANTED;
				res_holder_q <= req_t_q;
			end else if (is_owner) begin
				res_status_q <= ltdd_pkg::ST_OWNER;
			end else begin
				res_status_q <= ltdd_pkg::ST_WAITING;
			end
		end
		if (cmd.walk) begin
			if (hit) begin
				res_status_q <= ltdd_pkg::ST_DEADLOCK;
				res_dead_q   <= ltdd_pkg::TID_W'(start_q);
			end else if (fail) begin
				start_q <= start_q + 1'b1;
				cur_q   <= start_q + 1'b1;
				cnt_q   <= '0;
			end else begin
				cur_q <= TV_W'(owner_rd);
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.publish) begin
			out_status_q <= res_status_q;
			out_holder_q <= res_holder_q;
			out_dead_q   <= res_dead_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign holder_thread   = out_holder_q;
	assign deadlock_thread = out_dead_q;

	`LTDD_ASSERT_IMPL(a_halt_ignores, cmd.decide && halted_q, !sts.dec_wait, "halted block recorded a wait")
	`LTDD_ASSERT_IMPL(a_dead_named, out_valid_q && (out_status_q == ltdd_pkg::ST_DEADLOCK), out_dead_q != '0, "deadlock word without a thread")
	`LTDD_ASSERT_IMPL(a_dead_only, out_valid_q && (out_status_q != ltdd_pkg::ST_DEADLOCK), out_dead_q == '0, "thread named without a deadlock")

endmodule
